FILE: rtl/ccw_pkg.sv
// ----------------------------------------------------------------------------
// ccw_pkg: shared constants for the coin change ways counter
// Field widths, the prime modulus and the default table depth.
// ----------------------------------------------------------------------------
package ccw_pkg;

    localparam int COIN_W = 20;
    localparam int TGT_W  = 12;
    localparam int WAY_W  = 30;

    localparam int DEFAULT_TABLE_DEPTH = 4096;

    // counts are kept modulo this prime
    localparam logic [WAY_W-1:0] WAYS_PRIME = WAY_W'(1000000007);

    // add two residues below the prime, one conditional subtract
    function automatic logic [WAY_W-1:0] mod_add(input logic [WAY_W-1:0] a,
                                                 input logic [WAY_W-1:0] b);
        logic [WAY_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, WAYS_PRIME})
        begin
            sum = sum - {1'b0, WAYS_PRIME};
        end
        return sum[WAY_W-1:0];
    endfunction

endpackage

FILE: rtl/coin_change_ways_counter_core.sv
// ----------------------------------------------------------------------------
// coin_change_ways_counter_core: coin change combinations counter
// Counts unordered coin combinations reaching target_sum, modulo 1000000007.
//
//   channel   direction  handshake               payload
//   -------   ---------  ----------------------  ------------------------------
//   input     in         in_valid / in_ready     coin_value, first_coin, last_coin
//   output    out        out_valid / out_ready   way_count
//   config    in         cfg_write_en            cfg_write_data (target_sum)
//
// A coin word is accepted, then entries 0 to top are swept and written back,
// top being target_sum clamped to TABLE_DEPTH - 1; a last coin then passes
// its count on to the holding word.
// Reset clears control only; the table holds nothing until a first coin.
// A finished count sits in a holding word and then the output register, so
// the next coin is taken while out_ready is low; one more count then stalls.
// ----------------------------------------------------------------------------
module coin_change_ways_counter_core
    import ccw_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [TGT_W-1:0]  cfg_write_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [COIN_W-1:0] coin_value,
    input  logic              first_coin,
    input  logic              last_coin,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WAY_W-1:0]  way_count
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W  = ((ADDR_W > TGT_W) ? ADDR_W : TGT_W) + 1;

    logic [TGT_W-1:0]  target_reg;
    logic [CMP_W-1:0]  top_ext;
    logic [ADDR_W-1:0] top_addr;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [WAY_W-1:0]  rd_data_a;
    logic [WAY_W-1:0]  rd_data_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WAY_W-1:0]  wr_data;

    logic              res_valid;
    logic [WAY_W-1:0]  res_data;
    logic              res_taken;
    logic              out_valid_reg;
    logic [WAY_W-1:0]  out_data_reg;

    // target register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            target_reg <= cfg_write_data;
        end
    end

    // clamp target to the last table entry
    assign top_ext  = (CMP_W'(target_reg) >= CMP_W'(TABLE_DEPTH)) ?
                      CMP_W'(TABLE_DEPTH - 1) : CMP_W'(target_reg);
    assign top_addr = top_ext[ADDR_W-1:0];

    ccw_sweep_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_sweep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .coin_value (coin_value),
        .first_coin (first_coin),
        .last_coin  (last_coin),
        .top_addr   (top_addr),
        .rd_en      (rd_en),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_taken  (res_taken)
    );

    ccw_ways_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // output register, loads when empty or being emptied
    assign res_taken = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_taken)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign way_count = out_data_reg;

endmodule

FILE: rtl/ccw_ways_mem.sv
// ----------------------------------------------------------------------------
// ccw_ways_mem: ways table storage
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ccw_ways_mem
    import ccw_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WAY_W-1:0]  rd_data_a,
    output logic [WAY_W-1:0]  rd_data_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WAY_W-1:0]  wr_data
);

    logic [WAY_W-1:0] mem [TABLE_DEPTH];
    logic [WAY_W-1:0] rd_a_reg;
    logic [WAY_W-1:0] rd_b_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read ports, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: rtl/ccw_sweep_ctrl.sv
// ----------------------------------------------------------------------------
// ccw_sweep_ctrl: per-coin table sweep
// Issues reads of entries s and s - coin, adds modulo the prime in the
// following cycle and writes entry s back, forwarding the entry just written.
// ----------------------------------------------------------------------------
module ccw_sweep_ctrl
    import ccw_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input words
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [COIN_W-1:0] coin_value,
    input  logic              first_coin,
    input  logic              last_coin,
    input  logic [ADDR_W-1:0] top_addr,
    // table
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr_a,
    output logic [ADDR_W-1:0] rd_addr_b,
    input  logic [WAY_W-1:0]  rd_data_a,
    input  logic [WAY_W-1:0]  rd_data_b,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [WAY_W-1:0]  wr_data,
    // finished count
    output logic              res_valid,
    output logic [WAY_W-1:0]  res_data,
    input  logic              res_taken
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    localparam int CMP_W = (COIN_W > ADDR_W) ? COIN_W : ADDR_W;

    logic              state_reg, state_next;
    logic [ADDR_W-1:0] s_reg, s_next;
    logic [ADDR_W-1:0] top_reg;
    logic [COIN_W-1:0] coin_reg;
    logic              first_reg;
    logic              last_reg;

    // write-back stage
    logic              p_valid_reg;
    logic [ADDR_W-1:0] p_addr_reg;
    logic              p_add_reg;
    logic              p_zero_reg;
    logic              p_fwd_reg;
    logic              p_final_reg;
    logic [WAY_W-1:0]  fwd_data_reg;

    logic              pend_valid_reg;
    logic [WAY_W-1:0]  pend_data_reg;

    logic              accept;
    logic              issue;
    logic              add_en;
    logic [WAY_W-1:0]  prev_val;
    logic [WAY_W-1:0]  add_val;
    logic [WAY_W-1:0]  new_val;

    assign in_ready = (state_reg == ST_IDLE) && !p_valid_reg && !pend_valid_reg;
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == ST_SWEEP);

    // read issue
    assign add_en    = (coin_reg != '0) && (CMP_W'(coin_reg) <= CMP_W'(s_reg));
    assign rd_en     = issue;
    assign rd_addr_a = s_reg;
    assign rd_addr_b = s_reg - coin_reg[ADDR_W-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        s_next     = s_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SWEEP;
                    s_next     = '0;
                end
            end
            ST_SWEEP:
            begin
                if (s_reg == top_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            p_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= issue;
            if (p_valid_reg && p_final_reg && last_reg)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (res_taken)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // coin word and pipeline payload
    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        if (accept)
        begin
            coin_reg  <= coin_value;
            first_reg <= first_coin;
            last_reg  <= last_coin;
            top_reg   <= top_addr;
        end
        p_addr_reg  <= s_reg;
        p_add_reg   <= add_en;
        p_zero_reg  <= (s_reg == '0);
        p_final_reg <= (s_reg == top_reg);
        // entry s - coin is being written this very cycle
        p_fwd_reg   <= p_valid_reg && (rd_addr_b == p_addr_reg);
        if (p_valid_reg)
        begin
            fwd_data_reg <= new_val;
        end
        if (p_valid_reg && p_final_reg && last_reg)
        begin
            pend_data_reg <= new_val;
        end
    end

    // modify and write back
    assign prev_val = first_reg ? '0 : rd_data_a;
    assign add_val  = !p_add_reg ? '0 : (p_fwd_reg ? fwd_data_reg : rd_data_b);
    assign new_val  = p_zero_reg ? WAY_W'(1) : mod_add(prev_val, add_val);

    assign wr_en   = p_valid_reg;
    assign wr_addr = p_addr_reg;
    assign wr_data = new_val;

    assign res_valid = pend_valid_reg;
    assign res_data  = pend_data_reg;

endmodule

FILE: bench/coin_change_ways_counter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coin_change_ways_counter_core_test: self-checking bench for the ways counter
// A short table of hand-picked coins and targets goes first. Randomised coin
// problems follow at several targets, including 0 and 4095. Every count that
// comes out is compared with its typed count or a local copy of the ways table
// kept in step with each accepted coin. Both channels idle at random. One phase
// holds the output off so long that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
module coin_change_ways_counter_core_test;
    import ccw_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int HOLD_CYCLES = 500;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DIR_ROWS    = 23;
    localparam int EXP_DEPTH   = 256;

    // one row of the directed table; want < 0 means take the predicted count
    typedef struct packed {
        logic [TGT_W-1:0]  tgt;
        logic [COIN_W-1:0] coin;
        logic              first;
        logic              last;
        int                want;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic [TGT_W-1:0]  cfg_write_data;
    logic              in_valid;
    logic              in_ready;
    logic [COIN_W-1:0] coin_value;
    logic              first_coin;
    logic              last_coin;
    logic              out_valid;
    logic              out_ready;
    logic [WAY_W-1:0]  way_count;

    // local copy of the core's state
    logic [TGT_W-1:0]  target_now = '0;
    int                written_top = -1;
    bit [WAY_W-1:0]    ways_tab [0:TABLE_DEPTH-1];

    // expected counts, written at exp_wr and read at exp_rd
    bit [WAY_W-1:0]    exp_counts [0:EXP_DEPTH-1];
    int                exp_wr = 0;
    int                exp_rd = 0;
    int                mismatches = 0;
    int                cycle_count = 0;
    bit                steady = 1'b0;
    bit                hold_req = 1'b0;

    // target, coin, first, last, count typed in where it is obvious
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{12'd0,    20'd5,       1'b1, 1'b1, 1},
        '{12'd0,    20'hFFFFF,   1'b1, 1'b1, 1},
        '{12'd10,   20'd0,       1'b1, 1'b1, 0},
        '{12'd10,   20'd1,       1'b1, 1'b1, 1},
        '{12'd10,   20'd10,      1'b1, 1'b1, 1},
        '{12'd10,   20'd11,      1'b1, 1'b1, 0},
        '{12'd10,   20'hFFFFF,   1'b1, 1'b1, 0},
        '{12'd10,   20'd2,       1'b1, 1'b0, -1},
        '{12'd10,   20'd5,       1'b0, 1'b0, -1},
        '{12'd10,   20'd3,       1'b0, 1'b0, -1},
        '{12'd10,   20'd6,       1'b0, 1'b1, -1},
        '{12'd10,   20'd1,       1'b0, 1'b1, -1},
        '{12'd10,   20'd1,       1'b1, 1'b0, -1},
        '{12'd10,   20'd0,       1'b0, 1'b1, 1},
        '{12'd4,    20'd1,       1'b1, 1'b0, -1},
        '{12'd4,    20'd2,       1'b0, 1'b1, 3},
        '{12'd4095, 20'd4095,    1'b1, 1'b1, 1},
        '{12'd4095, 20'd1,       1'b1, 1'b0, -1},
        '{12'd4095, 20'd2,       1'b0, 1'b1, 2048},
        '{12'd4095, 20'd3,       1'b0, 1'b0, -1},
        '{12'd4095, 20'd4,       1'b0, 1'b0, -1},
        '{12'd4095, 20'd5,       1'b0, 1'b0, -1},
        '{12'd4095, 20'd6,       1'b0, 1'b1, -1}
    };

    coin_change_ways_counter_core #(
        .TABLE_DEPTH    (TABLE_DEPTH)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .coin_value     (coin_value),
        .first_coin     (first_coin),
        .last_coin      (last_coin),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .way_count      (way_count)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("coin_change_ways_counter_core test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // target clamped to the last table entry
    function automatic int active_top();
        if (int'(target_now) >= TABLE_DEPTH)
        begin
            return TABLE_DEPTH - 1;
        end
        return int'(target_now);
    endfunction

    // one coin sweeps the ways table upward; gives the count when last is set
    function automatic void sweep_coin(input logic [COIN_W-1:0] c, input bit f,
                                       input bit l, output bit has,
                                       output bit [WAY_W-1:0] cnt);
        int top;
        longint unsigned acc;
        top = active_top();
        ways_tab[0] = WAY_W'(1);
        for (int s = 1; s <= top; s++)
        begin
            acc = f ? 64'd0 : 64'(ways_tab[s]);
            if (c != 0 && int'(c) <= s)
            begin
                acc = acc + 64'(ways_tab[s - int'(c)]);
            end
            if (acc >= longint'(WAYS_PRIME))
            begin
                acc = acc - longint'(WAYS_PRIME);
            end
            ways_tab[s] = WAY_W'(acc);
        end
        if (f && top > written_top)
        begin
            written_top = top;
        end
        has = l;
        cnt = ways_tab[top];
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_cycles();
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(40, 200);
    endfunction

    // mostly coins that fit the target, some zero, some from the full range
    function automatic logic [COIN_W-1:0] pick_coin();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            return '0;
        end
        if (r < 12)
        begin
            return COIN_W'($urandom);
        end
        return COIN_W'($urandom_range(1, active_top() + 1));
    endfunction

    // offer one coin word, wait for it to be taken, then log its count
    task automatic send_coin(input logic [COIN_W-1:0] c, input bit f, input bit l,
                             input int want);
        int n;
        bit has;
        bit [WAY_W-1:0] cnt;
        n = idle_cycles();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid   <= 1'b1;
        coin_value <= c;
        first_coin <= f;
        last_coin  <= l;
        do
            @(posedge clk);
        while (!in_ready);
        sweep_coin(c, f, l, has, cnt);
        if (has)
        begin
            exp_counts[exp_wr % EXP_DEPTH] = (want >= 0) ? WAY_W'(want) : cnt;
            exp_wr++;
        end
    endtask

    // wait for every count, then let the last sweep finish
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (2 * (active_top() + 2) + 16) @(posedge clk);
    endtask

    task automatic set_target(input logic [TGT_W-1:0] v);
        drain_and_settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        target_now = v;
    endtask

    // random coin problems at one target; press holds the output off first
    task automatic run_phase(input logic [TGT_W-1:0] tgt, input int items,
                             input int max_len, input bit press);
        int sent;
        int len;
        int kind;
        bit f;
        bit l;
        set_target(tgt);
        if (press)
        begin
            steady   = 1'b1;
            hold_req = 1'b1;
        end
        sent = 0;
        while (sent < items)
        begin
            len  = $urandom_range(1, max_len);
            if (len > items - sent)
            begin
                len = items - sent;
            end
            kind = $urandom_range(0, 99);
            for (int k = 0; k < len; k++)
            begin
                f = (k == 0);
                l = (k == len - 1);
                if (kind < 8)
                begin
                    // carry on from the table already held
                    if (k == 0)
                    begin
                        f = 1'b0;
                    end
                end
                else if (kind < 14)
                begin
                    // abandoned problem, never counted
                    l = 1'b0;
                end
                else if (kind < 18)
                begin
                    f = 1'($urandom_range(0, 1));
                    l = 1'($urandom_range(0, 1));
                end
                // never read entries that no sweep has written yet
                if (!f && active_top() > written_top)
                begin
                    f = 1'b1;
                end
                send_coin(pick_coin(), f, l, -1);
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    // output side: random back-pressure, one long hold when asked
    initial
    begin
        int n;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
            begin
                n = idle_cycles();
            end
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // count checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_wr == exp_rd)
            begin
                report_mismatch($sformatf("count %0d with none outstanding", way_count));
            end
            else
            begin
                if (way_count !== exp_counts[exp_rd % EXP_DEPTH])
                begin
                    report_mismatch($sformatf("way_count %0d, expected %0d",
                                              way_count, exp_counts[exp_rd % EXP_DEPTH]));
                end
                exp_rd++;
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        coin_value     <= '0;
        first_coin     <= 1'b0;
        last_coin      <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, target taken from each row
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].tgt != target_now)
            begin
                set_target(dir_rows[i].tgt);
            end
            send_coin(dir_rows[i].coin, dir_rows[i].first, dir_rows[i].last,
                      dir_rows[i].want);
        end

        // random problems over a spread of targets
        run_phase(TGT_W'($urandom_range(1, 40)), 18, 6, 1'b0);
        run_phase('0, 8, 4, 1'b0);
        run_phase(TGT_W'(5), 28, 2, 1'b1);
        run_phase(TGT_W'($urandom_range(41, 300)), 18, 6, 1'b0);
        run_phase('1, 6, 3, 1'b0);
        run_phase(TGT_W'($urandom_range(1, 12)), 25, 6, 1'b0);
        run_phase(TGT_W'($urandom_range(301, 1000)), 14, 5, 1'b0);

        drain_and_settle();
        if (mismatches == 0)
        begin
            $display("coin_change_ways_counter_core test passed");
        end
        else
        begin
            $display("coin_change_ways_counter_core test failed");
        end
        $finish;
    end

endmodule
